FILE: rtl/core/bmf_pkg.sv
// Shared widths, reset values and item structs for the 13x13 box mean filter.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package bmf_pkg;

    localparam int PIX_W       = 8;    // source pixel
    localparam int CSUM_W      = 12;   // vertical column sum
    localparam int WSUM_W      = 16;   // window sum
    localparam int MEAN_W      = 8;    // mean result
    localparam int CCOL_W      = 8;    // reported centre column
    localparam int ROW_W       = 10;   // row counter, frame height, centre row

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;

    localparam int LINE_WIDTH_DEF = 256;
    localparam int RADIUS_DEF     = 6;

    localparam logic [ROW_W-1:0] HEIGHT_RST = 10'd64;

    // fixed-point shift of the reciprocal used for the divide by window area
    localparam int RECIP_SHIFT = 24;

    typedef struct packed {
        logic row_zero;   // first row of the frame: column sums start from zero
        logic row_full;   // a full window of rows is stored: drop the oldest pixel
        logic col_zero;   // first column: window sum restarts
        logic col_full;   // a full window of columns seen: drop the oldest column sum
        logic emit;       // interior pixel, a result is produced
    } item_ctl_t;

    typedef struct packed {
        logic [CCOL_W-1:0] center_column;
        logic [ROW_W-1:0]  center_row;
        logic              frame_done;
    } res_tag_t;

endpackage

FILE: rtl/core/bmf_position.sv
// Raster position tracking, frame height register and row-store addressing.
// Depends on bmf_pkg.
module bmf_position #(
    parameter int LINE_WIDTH = bmf_pkg::LINE_WIDTH_DEF,
    parameter int RADIUS     = bmf_pkg::RADIUS_DEF,
    localparam int CIW       = $clog2(LINE_WIDTH),
    localparam int ADDR_W    = $clog2((2 * RADIUS + 1) * LINE_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bmf_pkg::ROW_W-1:0]   cfg_wdata,
    input  logic                        accept,
    input  logic                        frame_start,
    output logic [CIW-1:0]              col,
    output logic [ADDR_W-1:0]           addr,
    output bmf_pkg::item_ctl_t          ctl,
    output bmf_pkg::res_tag_t           tag
);

    localparam int WIN_SIDE = 2 * RADIUS + 1;
    localparam int RW       = bmf_pkg::ROW_W;
    localparam int XW       = CIW + bmf_pkg::CCOL_W;

    logic [CIW-1:0]    col_reg,  col_next;
    logic [RW-1:0]     row_reg,  row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [RW-1:0]     height_reg;

    logic [CIW-1:0]    col_cur;
    logic [RW-1:0]     row_cur;
    logic [ADDR_W-1:0] base_cur;
    logic              col_last;
    logic [RW:0]       row_inc;
    logic              row_last;
    logic [XW-1:0]     ccol_wide;

    // a frame start restarts this very word at pixel (0,0)
    assign col_cur  = frame_start ? '0 : col_reg;
    assign row_cur  = frame_start ? '0 : row_reg;
    assign base_cur = frame_start ? '0 : base_reg;

    assign col_last = (col_cur == CIW'(LINE_WIDTH - 1));
    assign row_inc  = {1'b0, row_cur} + (RW + 1)'(1);
    assign row_last = (row_inc >= {1'b0, height_reg});

    assign col  = col_cur;
    assign addr = base_cur + ADDR_W'(col_cur);

    assign ccol_wide = XW'(col_cur) - XW'(RADIUS);

    always_comb
    begin
        ctl.row_zero = (row_cur == '0);
        ctl.row_full = (row_cur >= RW'(WIN_SIDE));
        ctl.col_zero = (col_cur == '0);
        ctl.col_full = (col_cur >= CIW'(WIN_SIDE));
        ctl.emit     = (col_cur >= CIW'(2 * RADIUS)) && (row_cur >= RW'(2 * RADIUS))
                       && (row_cur < height_reg);
        tag.center_column = ccol_wide[bmf_pkg::CCOL_W-1:0];
        tag.center_row    = row_cur - RW'(RADIUS);
        tag.frame_done    = col_last && (row_inc == {1'b0, height_reg});
    end

    always_comb
    begin
        col_next  = col_cur + CIW'(1);
        row_next  = row_cur;
        base_next = base_cur;
        if (col_last)
        begin
            col_next = '0;
            if (row_last)
            begin
                row_next  = '0;
                base_next = '0;
            end
            else
            begin
                row_next  = row_inc[RW-1:0];
                base_next = (base_cur == ADDR_W'((WIN_SIDE - 1) * LINE_WIDTH)) ? '0
                            : base_cur + ADDR_W'(LINE_WIDTH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            height_reg <= bmf_pkg::HEIGHT_RST;
        else if (cfg_we)
            height_reg <= cfg_wdata;
    end

endmodule

FILE: rtl/core/bmf_column.sv
// Row store and column-sum memories; forms the running vertical sum per pixel.
// Depends on bmf_pkg.
module bmf_column #(
    parameter int LINE_WIDTH = bmf_pkg::LINE_WIDTH_DEF,
    parameter int RADIUS     = bmf_pkg::RADIUS_DEF,
    localparam int CIW       = $clog2(LINE_WIDTH),
    localparam int ADDR_W    = $clog2((2 * RADIUS + 1) * LINE_WIDTH)
) (
    input  logic                         clk,
    input  logic                         accept,
    input  logic                         adv1,
    input  logic [bmf_pkg::PIX_W-1:0]    pixel,
    input  logic [CIW-1:0]               col,
    input  logic [ADDR_W-1:0]            addr,
    input  bmf_pkg::item_ctl_t           ctl_in,
    input  bmf_pkg::res_tag_t            tag_in,
    output logic [bmf_pkg::CSUM_W-1:0]   cs,
    output bmf_pkg::item_ctl_t           ctl_out,
    output bmf_pkg::res_tag_t            tag_out
);

    localparam int STORE_DEPTH = (2 * RADIUS + 1) * LINE_WIDTH;
    localparam int CW          = bmf_pkg::CSUM_W;
    localparam int PW          = bmf_pkg::PIX_W;

    logic [PW-1:0] store_mem [STORE_DEPTH];
    logic [CW-1:0] colsum_mem [LINE_WIDTH];

    logic [PW-1:0]     pix1_reg;
    logic [CIW-1:0]    col1_reg;
    logic [ADDR_W-1:0] addr1_reg;
    bmf_pkg::item_ctl_t ctl1_reg;
    bmf_pkg::res_tag_t  tag1_reg;
    logic [PW-1:0]     store_rd_reg;
    logic [CW-1:0]     colsum_rd_reg;

    logic [CW-1:0]     cs_next;
    logic [CW-1:0]     cs2_reg;
    bmf_pkg::item_ctl_t ctl2_reg;
    bmf_pkg::res_tag_t  tag2_reg;

    // read at entry to stage 1, write back when the word leaves it
    always_ff @(posedge clk)
    begin
        if (adv1)
            store_mem[addr1_reg] <= pix1_reg;
        if (accept)
            store_rd_reg <= store_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            colsum_mem[col1_reg] <= cs_next;
        if (accept)
            colsum_rd_reg <= colsum_mem[col];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg  <= pixel;
            col1_reg  <= col;
            addr1_reg <= addr;
            ctl1_reg  <= ctl_in;
            tag1_reg  <= tag_in;
        end
    end

    // first row ignores stale sums; from a full window on, the pixel 13 rows up drops out
    assign cs_next = (ctl1_reg.row_zero ? '0 : colsum_rd_reg) + CW'(pix1_reg)
                     - (ctl1_reg.row_full ? CW'(store_rd_reg) : '0);

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cs2_reg  <= cs_next;
            ctl2_reg <= ctl1_reg;
            tag2_reg <= tag1_reg;
        end
    end

    assign cs      = cs2_reg;
    assign ctl_out = ctl2_reg;
    assign tag_out = tag2_reg;

endmodule

FILE: rtl/core/bmf_window.sv
// Horizontal running sum over the last 2*RADIUS+1 column sums of a row.
// Depends on bmf_pkg.
module bmf_window #(
    parameter int RADIUS = bmf_pkg::RADIUS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv2,
    input  logic [bmf_pkg::CSUM_W-1:0]   cs,
    input  bmf_pkg::item_ctl_t           ctl_in,
    input  bmf_pkg::res_tag_t            tag_in,
    output logic [bmf_pkg::WSUM_W-1:0]   ws,
    output logic                         emit,
    output bmf_pkg::res_tag_t            tag_out
);

    localparam int WIN_SIDE = 2 * RADIUS + 1;
    localparam int CW       = bmf_pkg::CSUM_W;
    localparam int WW       = bmf_pkg::WSUM_W;

    logic [CW-1:0] recent_reg [WIN_SIDE];
    logic [WW-1:0] window_sum_reg, window_sum_next;
    logic          emit3_reg;
    bmf_pkg::res_tag_t tag3_reg;

    always_comb
    begin
        if (ctl_in.col_zero)
            window_sum_next = WW'(cs);
        else
            window_sum_next = window_sum_reg + WW'(cs)
                              - (ctl_in.col_full ? WW'(recent_reg[WIN_SIDE-1]) : '0);
    end

    // the window sum register doubles as the stage-3 payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg <= '0;
            for (int i = 0; i < WIN_SIDE; i++)
                recent_reg[i] <= '0;
        end
        else if (adv2)
        begin
            window_sum_reg <= window_sum_next;
            recent_reg[0]  <= cs;
            for (int i = 1; i < WIN_SIDE; i++)
                recent_reg[i] <= recent_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            emit3_reg <= ctl_in.emit;
            tag3_reg  <= tag_in;
        end
    end

    assign ws      = window_sum_reg;
    assign emit    = emit3_reg;
    assign tag_out = tag3_reg;

endmodule

FILE: rtl/core/bmf_divide.sv
// Divide by window area via a reciprocal multiply, into the result register.
// Depends on bmf_pkg.
module bmf_divide #(
    parameter int RADIUS = bmf_pkg::RADIUS_DEF
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [bmf_pkg::WSUM_W-1:0]   ws,
    input  bmf_pkg::res_tag_t            tag_in,
    output logic [bmf_pkg::MEAN_W-1:0]   mean,
    output bmf_pkg::res_tag_t            tag_out
);

    localparam int AREA    = (2 * RADIUS + 1) * (2 * RADIUS + 1);
    localparam int SH      = bmf_pkg::RECIP_SHIFT;
    // rounded-up reciprocal; error times any 16-bit sum stays below 2^SH, so exact
    localparam int RECIP   = ((1 << SH) + AREA - 1) / AREA;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = bmf_pkg::WSUM_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic [bmf_pkg::MEAN_W-1:0] mean_reg;
    bmf_pkg::res_tag_t tag_reg;

    assign prod = PROD_W'(ws) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_reg <= prod[SH +: bmf_pkg::MEAN_W];
            tag_reg  <= tag_in;
        end
    end

    assign mean    = mean_reg;
    assign tag_out = tag_reg;

endmodule

FILE: rtl/core/box_mean_filter_13x13.sv
// Top level of the box mean filter: stream ports, pipeline flow control.
// Depends on bmf_pkg, bmf_position, bmf_column, bmf_window, bmf_divide.
//
//  channel  dir  fields (lowest bit first)                       taken when
//  -------  ---  ----------------------------------------------  -----------------------
//  s_*      in   tdata: pixel_value[7:0]; tuser: frame_start      s_tvalid & s_tready
//  m_*      out  tdata: mean_value[7:0], center_column[15:8],     m_tvalid & m_tready
//                center_row[25:16], zero pad; tlast: frame_done
//  cfg_*    in   wdata: frame_height[9:0]                         cfg_we
//
// One word per cycle sustained unless m_tready stalls the output. Four register
// stages (position/memory read, column sum, window sum, reciprocal multiply
// into the result register); m_tvalid shows a result once its pixel is through all four.
// Asynchronous reset clears position counters, stage valids and the window
// sum; frame height resets to 64. Memories need no clearing pass: column sums
// restart from zero on the first row of every frame.
// Stalls pass back combinationally along the ready chain; words that give no
// result leave the last stage even while a result waits, so input keeps flowing until full.
module box_mean_filter_13x13 #(
    parameter int LINE_WIDTH = bmf_pkg::LINE_WIDTH_DEF,
    parameter int RADIUS     = bmf_pkg::RADIUS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config: frame_height[9:0]
    input  logic                                cfg_we,
    input  logic [bmf_pkg::ROW_W-1:0]           cfg_wdata,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bmf_pkg::TDATA_IN_W-1:0]      s_tdata,   // pixel_value[7:0]
    input  logic                                s_tuser,   // frame_start
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bmf_pkg::TDATA_OUT_W-1:0]     m_tdata,   // mean, centre col, centre row
    output logic                                m_tlast    // frame_done
);

    localparam int CIW    = $clog2(LINE_WIDTH);
    localparam int ADDR_W = $clog2((2 * RADIUS + 1) * LINE_WIDTH);
    localparam int PAD_W  = bmf_pkg::TDATA_OUT_W - bmf_pkg::MEAN_W
                            - bmf_pkg::CCOL_W - bmf_pkg::ROW_W;

    // stage valids
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic out_valid_reg, out_valid_next;

    logic accept, adv1, adv2, adv3;
    logic rdy1, rdy2, rdy3, out_free;
    logic emit3;

    logic [CIW-1:0]    pos_col;
    logic [ADDR_W-1:0] pos_addr;
    bmf_pkg::item_ctl_t pos_ctl, ctl2;
    bmf_pkg::res_tag_t  pos_tag, tag2, tag3, out_tag;
    logic [bmf_pkg::CSUM_W-1:0] cs2;
    logic [bmf_pkg::WSUM_W-1:0] ws3;
    logic [bmf_pkg::MEAN_W-1:0] mean;

    // backpressure chain; a stage moves on when the one after is empty or moving, the last also when it gives no result
    assign out_free = !out_valid_reg || m_tready;
    assign adv3     = v3_reg && (!emit3 || out_free);
    assign rdy3     = !v3_reg || adv3;
    assign adv2     = v2_reg && rdy3;
    assign rdy2     = !v2_reg || adv2;
    assign adv1     = v1_reg && rdy2;
    assign rdy1     = !v1_reg || adv1;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    always_comb
    begin
        v1_next        = accept || (v1_reg && !adv1);
        v2_next        = adv1   || (v2_reg && !adv2);
        v3_next        = adv2   || (v3_reg && !adv3);
        out_valid_next = (adv3 && emit3) || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    bmf_position #(
        .LINE_WIDTH (LINE_WIDTH),
        .RADIUS     (RADIUS)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .frame_start (s_tuser),
        .col         (pos_col),
        .addr        (pos_addr),
        .ctl         (pos_ctl),
        .tag         (pos_tag)
    );

    bmf_column #(
        .LINE_WIDTH (LINE_WIDTH),
        .RADIUS     (RADIUS)
    ) u_column (
        .clk     (clk),
        .accept  (accept),
        .adv1    (adv1),
        .pixel   (s_tdata[bmf_pkg::PIX_W-1:0]),
        .col     (pos_col),
        .addr    (pos_addr),
        .ctl_in  (pos_ctl),
        .tag_in  (pos_tag),
        .cs      (cs2),
        .ctl_out (ctl2),
        .tag_out (tag2)
    );

    bmf_window #(
        .RADIUS (RADIUS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv2    (adv2),
        .cs      (cs2),
        .ctl_in  (ctl2),
        .tag_in  (tag2),
        .ws      (ws3),
        .emit    (emit3),
        .tag_out (tag3)
    );

    bmf_divide #(
        .RADIUS (RADIUS)
    ) u_divide (
        .clk     (clk),
        .load    (adv3 && emit3),
        .ws      (ws3),
        .tag_in  (tag3),
        .mean    (mean),
        .tag_out (out_tag)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_tag.center_row, out_tag.center_column, mean};
    assign m_tlast  = out_tag.frame_done;

endmodule
